// ===== rtl/tanwu_pkg.sv =====
// ----------------------------------------------------------------------------
// tanwu_pkg
// Shared widths, constants, stage types and the CORDIC arctangent table for
// the fixed-point tangent block.
// ----------------------------------------------------------------------------
package tanwu_pkg;

    // field and datapath widths
    localparam int ANGLE_W = 32;
    localparam int TAN_W   = 32;
    localparam int CW      = 47;   // CORDIC x / y, signed
    localparam int ZW      = 33;   // CORDIC residual angle, signed
    localparam int UW      = 31;   // folded first-quadrant phase
    localparam int XW      = 45;   // divisor and partial remainder
    localparam int NCORDIC = 30;
    localparam int NDIV    = 32;

    // angle unit codes
    localparam logic [1:0] UNIT_TURN = 2'd0;
    localparam logic [1:0] UNIT_RAD  = 2'd1;
    localparam logic [1:0] UNIT_DEG  = 2'd2;

    // radians: 1/(2 pi) in Q48, split in two 24-bit halves
    localparam logic [23:0] INV2PI_HI = 24'h28BE60;
    localparam logic [23:0] INV2PI_LO = 24'hDB9391;
    localparam logic [12:0] RAD_ROUND = 13'd2048;

    // degrees: phase = (mag * 512 + 22) / 45
    localparam logic [31:0] DEG_RECIP  = 32'd3054198966;  // floor(2^37 / 45)
    localparam logic [14:0] DEG_RECIP2 = 15'd23301;       // floor(2^20 / 45)
    localparam logic [5:0]  DEG_DIV    = 6'd45;
    localparam logic [14:0] DEG_BIAS   = 15'd22;

    // phase landmarks, 2^32 per turn
    localparam logic [UW-1:0] PHASE_QUARTER = 31'h4000_0000;
    localparam logic [31:0]   PHASE_HALF    = 32'h8000_0000;

    // CORDIC start vector and output limits
    localparam logic signed [CW-1:0] CORDIC_ONE = CW'(64'd1 << 44);
    localparam logic [TAN_W-1:0] TAN_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [TAN_W-1:0] TAN_NEG_MAX = 32'h8000_0000;

    // folded phase handed to the CORDIC chain
    typedef struct packed {
        logic [UW-1:0] u;
        logic          neg;
        logic          pole;
    } fold_t;

    // one CORDIC cell's state
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
        logic                 pole;
    } cordic_t;

    // one divider cell's state
    typedef struct packed {
        logic [XW-1:0]    x;
        logic [XW-1:0]    rem;
        logic [31:0]      nlow;
        logic [TAN_W-1:0] q;
        logic             neg;
        logic             sat;
        logic             pole;
    } div_t;

    // atan(2^-i) with 2^32 units per turn
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            5'd24:   val = 32'h0000_0029;
            5'd25:   val = 32'h0000_0014;
            5'd26:   val = 32'h0000_000A;
            5'd27:   val = 32'h0000_0005;
            5'd28:   val = 32'h0000_0003;
            5'd29:   val = 32'h0000_0001;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/tangent_with_angle_units.sv =====
// Pipeline: 9 phase stages, 30 CORDIC cells, 2 divider setup stages, 32 divider cells
//   and the output register lie between an input transfer and the result.
// Throughput: one item per cycle while the pipeline is not held; every unit is fully pipelined.
// A stalled output holds the pipeline only when its last stage carries an item.
// Reset (rst_n, asynchronous) empties the pipeline and sets angle_unit to turns.
// ----------------------------------------------------------------------------
// tangent_with_angle_units
// Fixed-point tangent of a Q12.20 angle in turns, radians or degrees, with a
// saturating Q16.16 result, built from a CORDIC cell chain and a divider chain.
// ----------------------------------------------------------------------------
module tangent_with_angle_units (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] angle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] tangent,
    output logic        saturated
);

    // configuration
    logic [1:0] angle_unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_unit_reg <= tanwu_pkg::UNIT_TURN;
        end
        else if (cfg_wen)
        begin
            angle_unit_reg <= cfg_wdata;
        end
    end

    // pipeline advance
    logic en;
    logic out_valid_reg, out_valid_next;
    logic last_valid;

    assign en       = !(out_valid_reg && out_stall) || !last_valid;
    assign in_stall = !en;

    // phase front end
    logic             fold_valid;
    tanwu_pkg::fold_t fold;

    tanwu_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .angle     (angle),
        .unit      (angle_unit_reg),
        .out_valid (fold_valid),
        .out_data  (fold)
    );

    // CORDIC cell chain
    tanwu_pkg::cordic_t          cor_data  [0:tanwu_pkg::NCORDIC];
    logic [tanwu_pkg::NCORDIC:0] cor_valid;
    tanwu_pkg::cordic_t          cor_start;

    always_comb
    begin
        cor_start.x    = tanwu_pkg::CORDIC_ONE;
        cor_start.y    = '0;
        cor_start.z    = $signed({2'b00, fold.u});
        cor_start.neg  = fold.neg;
        cor_start.pole = fold.pole;
    end

    assign cor_valid[0] = fold_valid;
    assign cor_data[0]  = cor_start;

    for (genvar i = 0; i < tanwu_pkg::NCORDIC; i++)
    begin : g_cordic
        tanwu_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cor_valid[i]),
            .in_data   (cor_data[i]),
            .out_valid (cor_valid[i+1]),
            .out_data  (cor_data[i+1])
        );
    end

    // divider setup A: sign and magnitude of the sine term
    tanwu_pkg::cordic_t           cor_last;
    logic [tanwu_pkg::CW-1:0]     y_abs;
    logic                         a_valid_reg;
    logic [tanwu_pkg::XW-1:0]     a_ay_reg,   a_ay_next;
    logic [tanwu_pkg::XW-1:0]     a_x_reg;
    logic                         a_xpos_reg, a_xpos_next;
    logic                         a_neg_reg,  a_neg_next;
    logic                         a_pole_reg;

    assign cor_last = cor_data[tanwu_pkg::NCORDIC];

    always_comb
    begin
        y_abs       = cor_last.y[tanwu_pkg::CW-1] ? (~cor_last.y + 1'b1) : cor_last.y;
        a_ay_next   = y_abs[tanwu_pkg::XW-1:0];
        a_neg_next  = cor_last.neg ^ cor_last.y[tanwu_pkg::CW-1];
        a_xpos_next = !cor_last.x[tanwu_pkg::CW-1] && (cor_last.x != '0);
    end

    // divider setup B: rounded numerator and range check
    logic [61:0]     numer;
    logic            b_valid_reg;
    tanwu_pkg::div_t b_data_reg, b_data_next;

    always_comb
    begin
        numer = 62'({a_ay_reg, 16'd0}) + 62'(a_x_reg[tanwu_pkg::XW-1:1]);
        b_data_next.x    = a_x_reg;
        b_data_next.rem  = tanwu_pkg::XW'(numer[61:32]);
        b_data_next.nlow = numer[31:0];
        b_data_next.q    = '0;
        b_data_next.neg  = a_neg_reg;
        b_data_next.pole = a_pole_reg;
        b_data_next.sat  = !a_xpos_reg || (tanwu_pkg::XW'(numer[61:32]) >= a_x_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= cor_valid[tanwu_pkg::NCORDIC];
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ay_reg   <= a_ay_next;
            a_x_reg    <= cor_last.x[tanwu_pkg::XW-1:0];
            a_xpos_reg <= a_xpos_next;
            a_neg_reg  <= a_neg_next;
            a_pole_reg <= cor_last.pole;
            b_data_reg <= b_data_next;
        end
    end

    // divider cell chain
    tanwu_pkg::div_t          div_data  [0:tanwu_pkg::NDIV];
    logic [tanwu_pkg::NDIV:0] div_valid;

    assign div_valid[0] = b_valid_reg;
    assign div_data[0]  = b_data_reg;

    for (genvar k = 0; k < tanwu_pkg::NDIV; k++)
    begin : g_div
        tanwu_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // saturate, restore sign, output register
    tanwu_pkg::div_t              div_last;
    logic [tanwu_pkg::TAN_W-1:0]  limit;
    logic [tanwu_pkg::TAN_W-1:0]  mag_q;
    logic [tanwu_pkg::TAN_W-1:0]  tangent_reg, tangent_next;
    logic                         saturated_reg, saturated_next;
    logic                         load;

    assign div_last   = div_data[tanwu_pkg::NDIV];
    assign last_valid = div_valid[tanwu_pkg::NDIV];
    assign load       = en && last_valid;

    always_comb
    begin
        limit = div_last.neg ? tanwu_pkg::TAN_NEG_MAX : tanwu_pkg::TAN_POS_MAX;
        if (div_last.sat || (div_last.q > limit))
        begin
            mag_q          = limit;
            saturated_next = 1'b1;
        end
        else
        begin
            mag_q          = div_last.q;
            saturated_next = 1'b0;
        end
        tangent_next = div_last.neg ? (~mag_q + 1'b1) : mag_q;
        // exact pole: a quarter turn modulo a half turn
        if (div_last.pole)
        begin
            tangent_next   = tanwu_pkg::TAN_POS_MAX;
            saturated_next = 1'b1;
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tangent_reg   <= tangent_next;
            saturated_reg <= saturated_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tangent   = tangent_reg;
    assign saturated = saturated_reg;

endmodule

// ===== rtl/tanwu_phase.sv =====
// ----------------------------------------------------------------------------
// tanwu_phase
// Nine-stage front end: converts the Q12.20 angle in the selected unit to a
// 32-bit phase and folds it into the first quadrant.
// ----------------------------------------------------------------------------
module tanwu_phase (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [31:0]           angle,
    input  logic [1:0]            unit,
    output logic                  out_valid,
    output tanwu_pkg::fold_t      out_data
);

    // stage valid bits
    logic [8:0] vld_reg;
    logic [8:0] vld_next;

    // payload registers, one group per stage
    logic [31:0]  raw_reg;
    logic [31:0]  mag1_reg,  mag1_next;
    logic         neg1_reg,  neg1_next;
    logic [55:0]  phi_reg,   phi_next;
    logic [55:0]  plo_reg,   plo_next;
    logic [63:0]  pr_reg,    pr_next;
    logic [31:0]  mag2_reg;
    logic         neg2_reg;
    logic [31:0]  rad3_reg,  rad3_next;
    logic [31:0]  turn3_reg, turn3_next;
    logic [26:0]  q1e_reg,   q1e_next;
    logic [6:0]   r0_reg,    r0_next;
    logic         neg3_reg;
    logic [31:0]  rad4_reg;
    logic [31:0]  turn4_reg;
    logic [26:0]  q1_reg,    q1_next;
    logic [14:0]  t4_reg,    t4_next;
    logic         neg4_reg;
    logic [31:0]  rad5_reg;
    logic [31:0]  turn5_reg;
    logic [26:0]  q15_reg;
    logic [14:0]  t5_reg;
    logic [9:0]   q2e_reg,   q2e_next;
    logic         neg5_reg;
    logic [31:0]  phm_reg,   phm_next;
    logic         neg6_reg;
    logic [31:0]  phase_reg, phase_next;
    tanwu_pkg::fold_t fold_reg, fold_next;

    // intermediates
    logic [56:0]  rad_sum;
    logic [32:0]  q1e_mul;
    logic [32:0]  r0_wide;
    logic [5:0]   r1;
    logic [29:0]  q2_prod;
    logic [15:0]  q2e_mul;
    logic [15:0]  r2_wide;
    logic [9:0]   q2;
    logic [31:0]  ph_deg;
    logic [31:0]  ph_full;

    // valid shift
    assign vld_next = {vld_reg[7:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // magnitude and sign
    always_comb
    begin
        neg1_next = raw_reg[31];
        mag1_next = raw_reg[31] ? (~raw_reg + 32'd1) : raw_reg;
    end

    // scale products for radians and degrees
    always_comb
    begin
        phi_next = 56'(mag1_reg) * 56'(tanwu_pkg::INV2PI_HI);
        plo_next = 56'(mag1_reg) * 56'(tanwu_pkg::INV2PI_LO);
        pr_next  = 64'(mag1_reg) * 64'(tanwu_pkg::DEG_RECIP);
    end

    // radians rounding, degrees first quotient estimate
    always_comb
    begin
        rad_sum    = 57'(phi_reg) + 57'(plo_reg[55:24]) + 57'(tanwu_pkg::RAD_ROUND);
        rad3_next  = rad_sum[43:12];
        turn3_next = {mag2_reg[19:0], 12'd0};
        q1e_next   = pr_reg[63:37];
        q1e_mul    = 33'(q1e_next) * 33'(tanwu_pkg::DEG_DIV);
        r0_wide    = 33'(mag2_reg) - q1e_mul;
        r0_next    = r0_wide[6:0];
    end

    // degrees: correct first quotient, form remainder term
    always_comb
    begin
        if (r0_reg >= 7'(tanwu_pkg::DEG_DIV))
        begin
            q1_next = q1e_reg + 27'd1;
            r1      = 6'(r0_reg - 7'(tanwu_pkg::DEG_DIV));
        end
        else
        begin
            q1_next = q1e_reg;
            r1      = r0_reg[5:0];
        end
        t4_next = {r1, 9'd0} + tanwu_pkg::DEG_BIAS;
    end

    // degrees: second quotient estimate
    always_comb
    begin
        q2_prod  = 30'(t4_reg) * 30'(tanwu_pkg::DEG_RECIP2);
        q2e_next = q2_prod[29:20];
    end

    // degrees: correct second quotient, then pick the unit
    always_comb
    begin
        q2e_mul = 16'(q2e_reg) * 16'(tanwu_pkg::DEG_DIV);
        r2_wide = 16'(t5_reg) - q2e_mul;
        q2      = (r2_wide >= 16'(tanwu_pkg::DEG_DIV)) ? (q2e_reg + 10'd1) : q2e_reg;
        ph_deg  = {q15_reg[22:0], 9'd0} + 32'(q2);
        unique case (unit)
            tanwu_pkg::UNIT_RAD: phm_next = rad5_reg;
            tanwu_pkg::UNIT_DEG: phm_next = ph_deg;
            default:             phm_next = turn5_reg;
        endcase
    end

    // restore the sign modulo one turn
    assign phase_next = neg6_reg ? (~phm_reg + 32'd1) : phm_reg;

    // fold into the first quadrant
    always_comb
    begin
        ph_full        = tanwu_pkg::PHASE_HALF - {1'b0, phase_reg[30:0]};
        fold_next.pole = (phase_reg[30:0] == tanwu_pkg::PHASE_QUARTER);
        if (phase_reg[30:0] < tanwu_pkg::PHASE_QUARTER)
        begin
            fold_next.u   = phase_reg[30:0];
            fold_next.neg = 1'b0;
        end
        else
        begin
            fold_next.u   = ph_full[30:0];
            fold_next.neg = 1'b1;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg   <= angle;
            mag1_reg  <= mag1_next;
            neg1_reg  <= neg1_next;
            phi_reg   <= phi_next;
            plo_reg   <= plo_next;
            pr_reg    <= pr_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            rad3_reg  <= rad3_next;
            turn3_reg <= turn3_next;
            q1e_reg   <= q1e_next;
            r0_reg    <= r0_next;
            neg3_reg  <= neg2_reg;
            rad4_reg  <= rad3_reg;
            turn4_reg <= turn3_reg;
            q1_reg    <= q1_next;
            t4_reg    <= t4_next;
            neg4_reg  <= neg3_reg;
            rad5_reg  <= rad4_reg;
            turn5_reg <= turn4_reg;
            q15_reg   <= q1_reg;
            t5_reg    <= t4_reg;
            q2e_reg   <= q2e_next;
            neg5_reg  <= neg4_reg;
            phm_reg   <= phm_next;
            neg6_reg  <= neg5_reg;
            phase_reg <= phase_next;
            fold_reg  <= fold_next;
        end
    end

    assign out_valid = vld_reg[8];
    assign out_data  = fold_reg;

endmodule

// ===== rtl/tanwu_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tanwu_cordic_cell
// One CORDIC rotation step: rotates (x, y) by +/- atan(2^-IDX) toward the
// residual angle and registers the result for the next cell.
// ----------------------------------------------------------------------------
module tanwu_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  tanwu_pkg::cordic_t     in_data,
    output logic                   out_valid,
    output tanwu_pkg::cordic_t     out_data
);

    logic                          valid_reg;
    tanwu_pkg::cordic_t            data_reg, data_next;
    logic signed [tanwu_pkg::CW-1:0] dx;
    logic signed [tanwu_pkg::CW-1:0] dy;
    logic signed [tanwu_pkg::ZW-1:0] step;

    // rotate toward zero residual
    always_comb
    begin
        dx   = in_data.y >>> IDX;
        dy   = in_data.x >>> IDX;
        step = $signed({1'b0, tanwu_pkg::atan_turns(5'(IDX))});
        data_next      = in_data;
        if (!in_data.z[tanwu_pkg::ZW-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - step;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/tanwu_div_cell.sv =====
// ----------------------------------------------------------------------------
// tanwu_div_cell
// One restoring-divide step: shifts the next numerator bit into the partial
// remainder, subtracts the divisor when it fits and appends a quotient bit.
// ----------------------------------------------------------------------------
module tanwu_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  tanwu_pkg::div_t    in_data,
    output logic               out_valid,
    output tanwu_pkg::div_t    out_data
);

    logic                      valid_reg;
    tanwu_pkg::div_t           data_reg, data_next;
    logic [tanwu_pkg::XW:0]    trial;
    logic [tanwu_pkg::XW:0]    diff;
    logic                      fits;

    // compare and subtract
    always_comb
    begin
        trial = {in_data.rem, in_data.nlow[31]};
        diff  = trial - {1'b0, in_data.x};
        fits  = (trial >= {1'b0, in_data.x});
        data_next      = in_data;
        data_next.rem  = fits ? diff[tanwu_pkg::XW-1:0] : trial[tanwu_pkg::XW-1:0];
        data_next.nlow = {in_data.nlow[30:0], 1'b0};
        data_next.q    = {in_data.q[tanwu_pkg::TAN_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/tanwu_checker.sv =====
// ----------------------------------------------------------------------------
// tanwu_checker
// Port-level checks for the tangent block, attached by bind.
// ----------------------------------------------------------------------------
module tanwu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] tangent,
    input logic        saturated
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output transfer dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(tangent) && $stable(saturated)))
        else $error("output payload changed while stalled");

    // a positive clamp sits at the top of the range
    a_sat_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated && !tangent[31]) |-> (tangent == 32'h7FFF_FFFF))
        else $error("positive saturation not at full scale");

    // a negative clamp sits at the bottom of the range
    a_sat_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated && tangent[31]) |-> (tangent == 32'h8000_0000))
        else $error("negative saturation not at full scale");

    // input stalls only behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

endmodule

bind tangent_with_angle_units tanwu_checker u_tanwu_checker (.*);
